[src/rbsor_pkg.sv]
// ----------------------------------------------------------------------------
// rbsor_pkg: shared types and constants for the SOR pressure cell
// Fixed-point widths, register map, reset values and pipeline timing.
// ----------------------------------------------------------------------------
package rbsor_pkg;

    localparam int FRAC_BITS = 24;
    localparam int DATA_W    = 48;
    localparam int REG_W     = 47;
    localparam int OMEGA_W   = 26;
    localparam int OPER_W    = DATA_W + 2;
    localparam int CFG_IDX_W = 3;

    localparam int QMUL_LAT   = 4;
    localparam int PIPE_DEPTH = 4 * QMUL_LAT + 5;

    localparam logic OP_RELAX    = 1'b0;
    localparam logic OP_RESIDUAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_DT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DX2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DY2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OMEGA   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG    = 3'd6;

    localparam logic [REG_W-1:0]   INV_DT_RST  = 47'd838860800;
    localparam logic [REG_W-1:0]   INV_DX_RST  = 47'd4294967296;
    localparam logic [REG_W-1:0]   INV_DY_RST  = 47'd4294967296;
    localparam logic [REG_W-1:0]   INV_DX2_RST = 47'd1099511627776;
    localparam logic [REG_W-1:0]   INV_DY2_RST = 47'd1099511627776;
    localparam logic [OMEGA_W-1:0] OMEGA_RST   = 26'd28521267;
    localparam logic [REG_W-1:0]   DIAG_RST    = 47'd64;

    typedef struct packed {
        logic [REG_W-1:0]   inv_time_step;
        logic [REG_W-1:0]   inv_cell_width;
        logic [REG_W-1:0]   inv_cell_height;
        logic [REG_W-1:0]   inv_width_squared;
        logic [REG_W-1:0]   inv_height_squared;
        logic [OMEGA_W-1:0] relax_factor;
        logic [REG_W-1:0]   diagonal_scale;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              clip;
    } fixed_out_t;

endpackage

[src/rbsor_cfg.sv]
// ----------------------------------------------------------------------------
// rbsor_cfg: configuration register file
// Seven coefficient registers loaded through a plain write port.
// ----------------------------------------------------------------------------
module rbsor_cfg
    import rbsor_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_time_step      <= INV_DT_RST;
            cfg_reg.inv_cell_width     <= INV_DX_RST;
            cfg_reg.inv_cell_height    <= INV_DY_RST;
            cfg_reg.inv_width_squared  <= INV_DX2_RST;
            cfg_reg.inv_height_squared <= INV_DY2_RST;
            cfg_reg.relax_factor       <= OMEGA_RST;
            cfg_reg.diagonal_scale     <= DIAG_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_INV_DT:  cfg_reg.inv_time_step      <= cfg_data;
                CFG_INV_DX:  cfg_reg.inv_cell_width     <= cfg_data;
                CFG_INV_DY:  cfg_reg.inv_cell_height    <= cfg_data;
                CFG_INV_DX2: cfg_reg.inv_width_squared  <= cfg_data;
                CFG_INV_DY2: cfg_reg.inv_height_squared <= cfg_data;
                CFG_OMEGA:   cfg_reg.relax_factor       <= cfg_data[OMEGA_W-1:0];
                CFG_DIAG:    cfg_reg.diagonal_scale     <= cfg_data;
                default:     cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/rbsor_delay.sv]
// ----------------------------------------------------------------------------
// rbsor_delay: enabled payload delay line
// Carries a word a fixed number of pipeline stages alongside the math.
// ----------------------------------------------------------------------------
module rbsor_delay
    import rbsor_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = QMUL_LAT
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

[src/rbsor_qmul.sv]
// ----------------------------------------------------------------------------
// rbsor_qmul: pipelined Q24.24 multiply by an unsigned coefficient
// Magnitude, four partial products, rounded sum, then clip and sign restore.
// ----------------------------------------------------------------------------
module rbsor_qmul
    import rbsor_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [OPER_W-1:0] oper,
    input  logic [REG_W-1:0]         coef,
    output fixed_out_t               prod
);

    localparam int A_LO_W = (OPER_W + 1) / 2;
    localparam int A_HI_W = OPER_W - A_LO_W;
    localparam int B_LO_W = (REG_W + 1) / 2;
    localparam int B_HI_W = REG_W - B_LO_W;
    localparam int PROD_W = OPER_W + REG_W;
    localparam int Q_W    = PROD_W - FRAC_BITS;

    localparam logic [PROD_W-1:0] ROUND   = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [Q_W-1:0]    LIM_POS = (Q_W'(1) << (DATA_W - 1)) - Q_W'(1);
    localparam logic [Q_W-1:0]    LIM_NEG = Q_W'(1) << (DATA_W - 1);

    logic [OPER_W-1:0]        mag_next;
    logic [OPER_W-1:0]        mag_reg;
    logic                     neg1_reg;
    logic [A_LO_W+B_LO_W-1:0] pp_ll_reg;
    logic [A_LO_W+B_HI_W-1:0] pp_lh_reg;
    logic [A_HI_W+B_LO_W-1:0] pp_hl_reg;
    logic [A_HI_W+B_HI_W-1:0] pp_hh_reg;
    logic                     neg2_reg;
    logic [PROD_W-1:0]        sum_next;
    logic [PROD_W-1:0]        sum_reg;
    logic                     neg3_reg;
    logic [Q_W-1:0]           quot;
    logic [Q_W-1:0]           lim;
    logic                     clip;
    logic [DATA_W-1:0]        mag_sat;
    fixed_out_t               prod_next;
    fixed_out_t               prod_reg;

    assign mag_next = oper[OPER_W-1] ? OPER_W'(-oper) : OPER_W'(oper);

    assign sum_next = PROD_W'(pp_ll_reg)
                    + (PROD_W'(pp_lh_reg) << B_LO_W)
                    + (PROD_W'(pp_hl_reg) << A_LO_W)
                    + (PROD_W'(pp_hh_reg) << (A_LO_W + B_LO_W))
                    + ROUND;

    always_comb
    begin
        quot            = sum_reg[PROD_W-1:FRAC_BITS];
        lim             = neg3_reg ? LIM_NEG : LIM_POS;
        clip            = quot > lim;
        mag_sat         = clip ? lim[DATA_W-1:0] : quot[DATA_W-1:0];
        prod_next.value = neg3_reg ? (DATA_W'(0) - mag_sat) : mag_sat;
        prod_next.clip  = clip;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag_next;
            neg1_reg  <= oper[OPER_W-1];
            pp_ll_reg <= mag_reg[A_LO_W-1:0] * coef[B_LO_W-1:0];
            pp_lh_reg <= mag_reg[A_LO_W-1:0] * coef[REG_W-1:B_LO_W];
            pp_hl_reg <= mag_reg[OPER_W-1:A_LO_W] * coef[B_LO_W-1:0];
            pp_hh_reg <= mag_reg[OPER_W-1:A_LO_W] * coef[REG_W-1:B_LO_W];
            neg2_reg  <= neg1_reg;
            sum_reg   <= sum_next;
            neg3_reg  <= neg2_reg;
            prod_reg  <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

[src/red_black_sor_pressure_cell.sv]
// ----------------------------------------------------------------------------
// red_black_sor_pressure_cell: one-cell SOR relaxation and residual engine
// Usage:
//   Input channel (in_valid/in_ready) takes one cell per transaction: opcode,
//   the center and four neighbor pressures, and F/G momentum pairs, Q24.24.
//   Output channel (out_valid/out_ready) returns one transaction per input:
//   the relaxed pressure (relax) or point residual (residual), plus a flag
//   set when any product or the final sum clipped to 48 bits.
//   The path from input transaction to output valid runs through four
//   chained four-stage multipliers (momentum and neighbor terms, rhs,
//   diagonal scale, omega) plus the add stages between them. Throughput is
//   one transaction per cycle while the output is not stalled.
//   When the output holds a result that is not taken, the whole pipeline
//   freezes and in_ready drops in the same cycle; nothing is lost.
//   Reset clears all pipeline valid bits and loads default coefficients.
//   Write coefficients through cfg_write/cfg_index/cfg_data only when no
//   transaction is in flight; indexes above six are ignored.
// ----------------------------------------------------------------------------
module red_black_sor_pressure_cell
    import rbsor_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [REG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     opcode,
    input  logic signed [DATA_W-1:0] p_center,
    input  logic signed [DATA_W-1:0] p_east,
    input  logic signed [DATA_W-1:0] p_west,
    input  logic signed [DATA_W-1:0] p_north,
    input  logic signed [DATA_W-1:0] p_south,
    input  logic signed [DATA_W-1:0] f_here,
    input  logic signed [DATA_W-1:0] f_west,
    input  logic signed [DATA_W-1:0] g_here,
    input  logic signed [DATA_W-1:0] g_south,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] result_value,
    output logic                     saturated
);

    localparam int ST_IN   = 1;
    localparam int ST_PROD = ST_IN + QMUL_LAT;
    localparam int ST_RSUM = ST_PROD + 1;
    localparam int ST_RHS  = ST_RSUM + QMUL_LAT;
    localparam int ST_S    = ST_RHS + 1;
    localparam int ST_T    = ST_S + QMUL_LAT;
    localparam int ST_DT   = ST_T + 1;
    localparam int ST_D    = ST_DT + QMUL_LAT;

    cfg_t cfg;
    logic adv;

    logic [PIPE_DEPTH:1] valid_reg;
    logic [PIPE_DEPTH:1] valid_next;

    logic                     s1_op_reg;
    logic [DATA_W-1:0]        s1_pc_reg;
    logic signed [OPER_W-1:0] s1_dfx_next;
    logic signed [OPER_W-1:0] s1_dgy_next;
    logic signed [OPER_W-1:0] s1_sumx_next;
    logic signed [OPER_W-1:0] s1_sumy_next;
    logic signed [OPER_W-1:0] s1_dfx_reg;
    logic signed [OPER_W-1:0] s1_dgy_reg;
    logic signed [OPER_W-1:0] s1_sumx_reg;
    logic signed [OPER_W-1:0] s1_sumy_reg;

    fixed_out_t rx_prod;
    fixed_out_t ry_prod;
    fixed_out_t sx_prod;
    fixed_out_t sy_prod;
    fixed_out_t rhs_prod;
    fixed_out_t t_prod;
    fixed_out_t d_prod;

    logic signed [OPER_W-1:0] s6_rsum_reg;
    logic                     s6_flag_reg;
    logic [2*DATA_W-1:0]      sxy_rhs;
    logic                     flag_rhs;

    logic signed [OPER_W-1:0] s11_s_next;
    logic signed [OPER_W-1:0] s11_s_reg;
    logic                     s11_flag_reg;
    fixed_out_t               s11_sat;
    fixed_out_t               s12_res1_reg;
    fixed_out_t               res1_d;

    logic [DATA_W-1:0]        pc_t;
    logic [DATA_W-1:0]        pc_d;
    logic                     flag_t;
    logic signed [OPER_W-1:0] s16_dt_reg;
    logic                     s16_flag_reg;
    logic                     flag_d;
    logic                     op_d;

    logic signed [OPER_W-1:0] relax_sum;
    fixed_out_t               relax_sat;
    fixed_out_t               out_next;
    fixed_out_t               out_reg;

    function automatic fixed_out_t clip_data(input logic signed [OPER_W-1:0] v);
        fixed_out_t r;
        logic       ovf;
        ovf = !((&v[OPER_W-1:DATA_W-1]) || !(|v[OPER_W-1:DATA_W-1]));
        r.clip = ovf;
        if (ovf)
        begin
            r.value = v[OPER_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                  : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            r.value = v[DATA_W-1:0];
        end
        return r;
    endfunction

    rbsor_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign adv       = !valid_reg[PIPE_DEPTH] || out_ready;
    assign in_ready  = adv;
    assign out_valid = valid_reg[PIPE_DEPTH];

    assign valid_next = {valid_reg[PIPE_DEPTH-1:1], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: operand sums
    always_comb
    begin
        s1_dfx_next = OPER_W'(f_here) - OPER_W'(f_west);
        s1_dgy_next = OPER_W'(g_here) - OPER_W'(g_south);
        if (opcode == OP_RESIDUAL)
        begin
            s1_sumx_next = OPER_W'(p_east) - (OPER_W'(p_center) <<< 1) + OPER_W'(p_west);
            s1_sumy_next = OPER_W'(p_north) - (OPER_W'(p_center) <<< 1) + OPER_W'(p_south);
        end
        else
        begin
            s1_sumx_next = OPER_W'(p_east) + OPER_W'(p_west);
            s1_sumy_next = OPER_W'(p_north) + OPER_W'(p_south);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg   <= opcode;
            s1_pc_reg   <= p_center;
            s1_dfx_reg  <= s1_dfx_next;
            s1_dgy_reg  <= s1_dgy_next;
            s1_sumx_reg <= s1_sumx_next;
            s1_sumy_reg <= s1_sumy_next;
        end
    end

    rbsor_qmul u_qmul_rx (
        .clk (clk), .en (adv), .oper (s1_dfx_reg),
        .coef (cfg.inv_cell_width), .prod (rx_prod)
    );

    rbsor_qmul u_qmul_ry (
        .clk (clk), .en (adv), .oper (s1_dgy_reg),
        .coef (cfg.inv_cell_height), .prod (ry_prod)
    );

    rbsor_qmul u_qmul_sx (
        .clk (clk), .en (adv), .oper (s1_sumx_reg),
        .coef (cfg.inv_width_squared), .prod (sx_prod)
    );

    rbsor_qmul u_qmul_sy (
        .clk (clk), .en (adv), .oper (s1_sumy_reg),
        .coef (cfg.inv_height_squared), .prod (sy_prod)
    );

    // Stage 6: right-hand side operand
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_rsum_reg <= OPER_W'($signed(rx_prod.value)) + OPER_W'($signed(ry_prod.value));
            s6_flag_reg <= rx_prod.clip | ry_prod.clip | sx_prod.clip | sy_prod.clip;
        end
    end

    rbsor_qmul u_qmul_rhs (
        .clk (clk), .en (adv), .oper (s6_rsum_reg),
        .coef (cfg.inv_time_step), .prod (rhs_prod)
    );

    rbsor_delay #(.WIDTH (2 * DATA_W), .DEPTH (ST_RHS - ST_PROD)) u_dly_sxy (
        .clk (clk), .en (adv),
        .d   ({sx_prod.value, sy_prod.value}),
        .q   (sxy_rhs)
    );

    rbsor_delay #(.WIDTH (1), .DEPTH (ST_RHS - ST_RSUM)) u_dly_flag6 (
        .clk (clk), .en (adv), .d (s6_flag_reg), .q (flag_rhs)
    );

    // Stage 11: neighbor sum minus right-hand side
    assign s11_s_next = OPER_W'($signed(sxy_rhs[2*DATA_W-1:DATA_W]))
                      + OPER_W'($signed(sxy_rhs[DATA_W-1:0]))
                      - OPER_W'($signed(rhs_prod.value));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s11_s_reg    <= s11_s_next;
            s11_flag_reg <= flag_rhs | rhs_prod.clip;
        end
    end

    assign s11_sat = clip_data(s11_s_reg);

    // Stage 12: residual result
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s12_res1_reg.value <= s11_sat.value;
            s12_res1_reg.clip  <= s11_flag_reg | s11_sat.clip;
        end
    end

    rbsor_delay #(.WIDTH ($bits(fixed_out_t)), .DEPTH (ST_D - ST_S - 1)) u_dly_res1 (
        .clk (clk), .en (adv), .d (s12_res1_reg), .q (res1_d)
    );

    rbsor_qmul u_qmul_t (
        .clk (clk), .en (adv), .oper (s11_s_reg),
        .coef (cfg.diagonal_scale), .prod (t_prod)
    );

    rbsor_delay #(.WIDTH (DATA_W), .DEPTH (ST_T - ST_IN)) u_dly_pc_t (
        .clk (clk), .en (adv), .d (s1_pc_reg), .q (pc_t)
    );

    rbsor_delay #(.WIDTH (1), .DEPTH (ST_T - ST_S)) u_dly_flag11 (
        .clk (clk), .en (adv), .d (s11_flag_reg), .q (flag_t)
    );

    // Stage 16: distance to the Jacobi target
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s16_dt_reg   <= OPER_W'($signed(t_prod.value)) - OPER_W'($signed(pc_t));
            s16_flag_reg <= flag_t | t_prod.clip;
        end
    end

    rbsor_qmul u_qmul_d (
        .clk (clk), .en (adv), .oper (s16_dt_reg),
        .coef (REG_W'(cfg.relax_factor)), .prod (d_prod)
    );

    rbsor_delay #(.WIDTH (DATA_W), .DEPTH (ST_D - ST_T)) u_dly_pc_d (
        .clk (clk), .en (adv), .d (pc_t), .q (pc_d)
    );

    rbsor_delay #(.WIDTH (1), .DEPTH (ST_D - ST_DT)) u_dly_flag16 (
        .clk (clk), .en (adv), .d (s16_flag_reg), .q (flag_d)
    );

    rbsor_delay #(.WIDTH (1), .DEPTH (ST_D - ST_IN)) u_dly_op (
        .clk (clk), .en (adv), .d (s1_op_reg), .q (op_d)
    );

    // Output stage: pick relax or residual result
    assign relax_sum = OPER_W'($signed(pc_d)) + OPER_W'($signed(d_prod.value));
    assign relax_sat = clip_data(relax_sum);

    always_comb
    begin
        if (op_d == OP_RELAX)
        begin
            out_next.value = relax_sat.value;
            out_next.clip  = flag_d | d_prod.clip | relax_sat.clip;
        end
        else
        begin
            out_next = res1_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign result_value = out_reg.value;
    assign saturated    = out_reg.clip;

    ast_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[ST_IN])
        else $error("accepted transaction missing from first stage");

    ast_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[PIPE_DEPTH] && !out_ready) |=> $stable(valid_reg))
        else $error("pipeline moved while output stalled");

    ast_fill_rate: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) <= $past($countones(valid_reg)) + 1)
        else $error("in-flight count grew by more than one");

endmodule
